>>> sv/cpbp_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded pool byte generator package
// Shared types, constants and remix functions for the cascaded pool byte
// random generator.
// ----------------------------------------------------------------------------
package cpbp_pkg;

	localparam int POOL_DEPTH = 256;
	localparam int IDX_W = $clog2(POOL_DEPTH);
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] MIX_XOR = 8'h1B;
	localparam logic [BYTE_W-1:0] MIX_ADD = 8'd13;
	localparam int MIX_SHL = 3;
	localparam int MIX_SHR = 5;
	localparam int MUL_SHIFT = 5;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_DEPTH - 1);

	typedef enum logic {
		REQ_SEED = 1'b0,
		REQ_GEN  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		SEL_FIRST  = 2'd0,
		SEL_SECOND = 2'd1,
		SEL_THIRD  = 2'd2
	} sel_t;

	typedef struct packed {
		logic              gen;
		logic [BYTE_W-1:0] entropy;
		logic [IDX_W-1:0]  addr1;
		logic [IDX_W-1:0]  addr2;
		logic [IDX_W-1:0]  addr3;
		sel_t              sel;
		logic              wrap1;
		logic              wrap2;
	} cmd_t;

	function automatic logic [BYTE_W-1:0] mix_first(input logic [BYTE_W-1:0] v,
			input logic [BYTE_W-1:0] fb);
		logic [BYTE_W-1:0] x;
		x = v ^ fb;
		x = x ^ (x << MIX_SHL);
		x = x ^ (x >> MIX_SHR);
		return x ^ MIX_XOR;
	endfunction

	// Multiply by 31 as a shift and a subtract, then add 13, modulo 256.
	function automatic logic [BYTE_W-1:0] mix_second(input logic [BYTE_W-1:0] v,
			input logic [BYTE_W-1:0] fb);
		logic [BYTE_W-1:0] x;
		x = v ^ fb;
		return (x << MUL_SHIFT) - x + MIX_ADD;
	endfunction

	function automatic logic [BYTE_W-1:0] mix_third(input logic [BYTE_W-1:0] v,
			input logic [BYTE_W-1:0] fb, input logic [2:0] s);
		logic [BYTE_W-1:0]   t;
		logic [2*BYTE_W-1:0] d;
		t = v ^ fb;
		d = {t, t} << s;
		return ~d[2*BYTE_W-1:BYTE_W];
	endfunction

endpackage

>>> sv/cpbp_front.sv
// ----------------------------------------------------------------------------
// Cascaded pool byte generator front end
// Accepts items, keeps the seed position and the three pool indices, and
// turns each item into a command with its pool addresses and cascade flags.
// ----------------------------------------------------------------------------
module cpbp_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [cpbp_pkg::BYTE_W-1:0] entropy,
	output logic                     push_valid,
	input  logic                     push_ready,
	output cpbp_pkg::cmd_t           push_cmd
);

	logic [cpbp_pkg::IDX_W-1:0] idx1_q;
	logic [cpbp_pkg::IDX_W-1:0] idx2_q;
	logic [cpbp_pkg::IDX_W-1:0] idx3_q;
	logic [cpbp_pkg::IDX_W-1:0] seed_pos_q;
	cpbp_pkg::sel_t             seed_sel_q;
	logic                       accept;
	logic                       is_gen;
	logic                       wrap1;
	logic                       wrap2;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;
	assign is_gen     = (cpbp_pkg::req_t'(req_type) == cpbp_pkg::REQ_GEN);
	assign wrap1      = (idx1_q == cpbp_pkg::IDX_LAST);
	assign wrap2      = wrap1 && (idx2_q == cpbp_pkg::IDX_LAST);

	always_comb begin
		push_cmd.gen     = is_gen;
		push_cmd.entropy = entropy;
		push_cmd.sel     = seed_sel_q;
		push_cmd.wrap1   = wrap1;
		push_cmd.wrap2   = wrap2;
		if (is_gen) begin
			push_cmd.addr1 = idx1_q;
			push_cmd.addr2 = idx2_q;
			push_cmd.addr3 = idx3_q;
		end else begin
			push_cmd.addr1 = seed_pos_q;
			push_cmd.addr2 = seed_pos_q;
			push_cmd.addr3 = seed_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx1_q     <= '0;
			idx2_q     <= '0;
			idx3_q     <= '0;
			seed_pos_q <= '0;
			seed_sel_q <= cpbp_pkg::SEL_FIRST;
		end else if (accept) begin
			if (is_gen) begin
				idx1_q <= idx1_q + 1'b1;
				if (wrap1) begin
					idx2_q <= idx2_q + 1'b1;
				end
				if (wrap2) begin
					idx3_q <= idx3_q + 1'b1;
				end
			end else begin
				unique case (seed_sel_q)
					cpbp_pkg::SEL_FIRST:  seed_sel_q <= cpbp_pkg::SEL_SECOND;
					cpbp_pkg::SEL_SECOND: seed_sel_q <= cpbp_pkg::SEL_THIRD;
					default: begin
						seed_sel_q <= cpbp_pkg::SEL_FIRST;
						seed_pos_q <= seed_pos_q + 1'b1;
					end
				endcase
			end
		end
	end

endmodule

>>> sv/cpbp_queue.sv
// ----------------------------------------------------------------------------
// Cascaded pool byte generator command queue
// Two-entry queue between the front end and the pool engine, with push and
// pop in the same cycle.
// ----------------------------------------------------------------------------
module cpbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cpbp_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cpbp_pkg::cmd_t pop_cmd
);

	cpbp_pkg::cmd_t entry_q [2];
	logic [1:0]     count_q;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/cpbp_back.sv
// ----------------------------------------------------------------------------
// Cascaded pool byte generator pool engine
// Holds the three pools, reads them when a command issues, and remixes and
// writes them as the command leaves stage one, with a bypass for a read that
// meets the write of the command just ahead. Results go to an output register.
// ----------------------------------------------------------------------------
module cpbp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  cpbp_pkg::cmd_t              cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cpbp_pkg::BYTE_W-1:0] random_byte
);

	logic [cpbp_pkg::BYTE_W-1:0] pool1 [cpbp_pkg::POOL_DEPTH];
	logic [cpbp_pkg::BYTE_W-1:0] pool2 [cpbp_pkg::POOL_DEPTH];
	logic [cpbp_pkg::BYTE_W-1:0] pool3 [cpbp_pkg::POOL_DEPTH];

	cpbp_pkg::cmd_t              cmd_s1;
	logic                        valid_s1;
	logic [cpbp_pkg::BYTE_W-1:0] rd1_s1;
	logic [cpbp_pkg::BYTE_W-1:0] rd2_s1;
	logic [cpbp_pkg::BYTE_W-1:0] rd3_s1;
	logic [cpbp_pkg::BYTE_W-1:0] p1_zero_q;
	logic                        out_valid_q;
	logic [cpbp_pkg::BYTE_W-1:0] random_byte_q;

	logic                        fire_s1;
	logic                        issue;
	logic                        we1;
	logic                        we2;
	logic                        we3;
	logic [cpbp_pkg::BYTE_W-1:0] wd1;
	logic [cpbp_pkg::BYTE_W-1:0] wd2;
	logic [cpbp_pkg::BYTE_W-1:0] wd3;
	logic [cpbp_pkg::BYTE_W-1:0] fb3;
	logic                        hit1;
	logic                        hit2;
	logic                        hit3;

	assign fire_s1   = valid_s1 && (!cmd_s1.gen || !out_valid_q || out_ready);
	assign cmd_ready = !valid_s1 || fire_s1;
	assign issue     = cmd_valid && cmd_ready;

	always_comb begin
		fb3 = p1_zero_q + cmd_s1.entropy;
		we1 = 1'b0;
		we2 = 1'b0;
		we3 = 1'b0;
		wd1 = cmd_s1.entropy;
		wd2 = cmd_s1.entropy;
		wd3 = cmd_s1.entropy;
		if (cmd_s1.gen) begin
			wd1 = cpbp_pkg::mix_first(rd1_s1, rd2_s1);
			wd2 = cpbp_pkg::mix_second(rd2_s1, rd3_s1);
			wd3 = cpbp_pkg::mix_third(rd3_s1, fb3, cmd_s1.addr3[2:0]);
			we1 = fire_s1;
			we2 = fire_s1 && cmd_s1.wrap1;
			we3 = fire_s1 && cmd_s1.wrap2;
		end else begin
			unique case (cmd_s1.sel)
				cpbp_pkg::SEL_FIRST:  we1 = fire_s1;
				cpbp_pkg::SEL_SECOND: we2 = fire_s1;
				cpbp_pkg::SEL_THIRD:  we3 = fire_s1;
				default: begin
					we1 = 1'b0;
				end
			endcase
		end
	end

	assign hit1 = we1 && (cmd_s1.addr1 == cmd.addr1);
	assign hit2 = we2 && (cmd_s1.addr2 == cmd.addr2);
	assign hit3 = we3 && (cmd_s1.addr3 == cmd.addr3);

	always_ff @(posedge clk) begin
		if (we1) begin
			pool1[cmd_s1.addr1] <= wd1;
		end
		if (issue) begin
			rd1_s1 <= hit1 ? wd1 : pool1[cmd.addr1];
		end
	end

	always_ff @(posedge clk) begin
		if (we2) begin
			pool2[cmd_s1.addr2] <= wd2;
		end
		if (issue) begin
			rd2_s1 <= hit2 ? wd2 : pool2[cmd.addr2];
		end
	end

	always_ff @(posedge clk) begin
		if (we3) begin
			pool3[cmd_s1.addr3] <= wd3;
		end
		if (issue) begin
			rd3_s1 <= hit3 ? wd3 : pool3[cmd.addr3];
		end
	end

	// Copy of the first entry of the first pool, used by the third pool refresh.
	always_ff @(posedge clk) begin
		if (we1 && (cmd_s1.addr1 == '0)) begin
			p1_zero_q <= wd1;
		end
		if (issue) begin
			cmd_s1 <= cmd;
		end
		if (fire_s1 && cmd_s1.gen) begin
			random_byte_q <= rd1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1 && cmd_s1.gen) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign random_byte = random_byte_q;

endmodule

>>> sv/cascaded_pool_byte_prng.sv
// ----------------------------------------------------------------------------
// Cascaded pool byte random generator
// Top level: front end, command queue and pool engine.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, seed or generate, unless a held-off
// output fills the command queue, and delivers one byte per cycle for a stream
// of generate items while out_ready stays high. A generate item's byte passes
// through the two-entry command queue and the pool read register, and its remix
// is computed as the byte enters the output register. Each pool is a single
// memory with one read and one write port, and the remix of an entry is written
// back as its command leaves the read stage, with a bypass so that an item that
// follows at once sees the new value. No clearing pass runs after reset; all
// 768 pool entries must be seeded before the first generate item.
module cascaded_pool_byte_prng (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [cpbp_pkg::BYTE_W-1:0] entropy,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cpbp_pkg::BYTE_W-1:0] random_byte
);

	logic           push_valid;
	logic           push_ready;
	cpbp_pkg::cmd_t push_cmd;
	logic           pop_valid;
	logic           pop_ready;
	cpbp_pkg::cmd_t pop_cmd;

	cpbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.entropy    (entropy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	cpbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	cpbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd_ready   (pop_ready),
		.cmd         (pop_cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_byte (random_byte)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded pool byte generator testbench
// Seeds all three pools, then drives directed, long cascade and random seed
// and generate traffic with idling and stalls on both channels. A local copy
// of the pools predicts each random byte, and every delivered byte is checked
// in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_GAP = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 824;
	localparam int CASCADE_GENS = 300;
	localparam logic [7:0] LEAD_XOR = 8'h1B;
	localparam logic [15:0] MID_MUL = 16'd31;
	localparam logic [15:0] MID_ADD = 16'd13;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             req_type;
	logic [7:0]       entropy;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       random_byte;

	logic [7:0]       lead_pool [cpbp_pkg::POOL_DEPTH];
	logic [7:0]       mid_pool [cpbp_pkg::POOL_DEPTH];
	logic [7:0]       tail_pool [cpbp_pkg::POOL_DEPTH];
	logic [7:0]       lead_idx = 8'd0;
	logic [7:0]       mid_idx = 8'd0;
	logic [7:0]       tail_idx = 8'd0;
	logic [7:0]       seed_row = 8'd0;
	cpbp_pkg::sel_t   seed_lane = cpbp_pkg::SEL_FIRST;
	logic [7:0]       pending_bytes [$];
	logic [7:0]       want;

	int               fail_count = 0;
	int               cycle_count = 0;
	int               send_idle_pct;
	int               recv_stall_pct;
	logic             hold_token;
	logic             hold_seen = 1'b0;
	int               hold_left = 0;

	cascaded_pool_byte_prng uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.entropy    (entropy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_byte(random_byte)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [7:0] scramble_lead(input logic [7:0] v, input logic [7:0] fb);
		logic [7:0] x;
		x = v ^ fb;
		x = x ^ {x[4:0], 3'b000};
		x = x ^ {5'b00000, x[7:5]};
		return x ^ LEAD_XOR;
	endfunction

	function automatic logic [7:0] scramble_mid(input logic [7:0] v, input logic [7:0] fb);
		logic [15:0] p;
		p = {8'h00, v ^ fb} * MID_MUL + MID_ADD;
		return p[7:0];
	endfunction

	function automatic logic [7:0] scramble_tail(input logic [7:0] v, input logic [7:0] fb,
			input logic [2:0] amount);
		logic [7:0] r;
		int k;
		r = v ^ fb;
		for (k = 0; k < amount; k++)
			r = {r[6:0], r[7]};
		return ~r;
	endfunction

	// Updates the local pools for one accepted item and queues the byte that a
	// generate item must deliver.
	function automatic void advance_pools(input cpbp_pkg::req_t req, input logic [7:0] ent);
		logic [7:0] drawn;
		logic [7:0] fb;
		if (req == cpbp_pkg::REQ_SEED) begin
			case (seed_lane)
				cpbp_pkg::SEL_FIRST: begin
					lead_pool[seed_row] = ent;
					seed_lane = cpbp_pkg::SEL_SECOND;
				end
				cpbp_pkg::SEL_SECOND: begin
					mid_pool[seed_row] = ent;
					seed_lane = cpbp_pkg::SEL_THIRD;
				end
				default: begin
					tail_pool[seed_row] = ent;
					seed_lane = cpbp_pkg::SEL_FIRST;
					seed_row = seed_row + 8'd1;
				end
			endcase
		end else begin
			drawn = lead_pool[lead_idx];
			lead_pool[lead_idx] = scramble_lead(drawn, mid_pool[mid_idx]);
			lead_idx = lead_idx + 8'd1;
			if (lead_idx == 8'd0) begin
				mid_pool[mid_idx] = scramble_mid(mid_pool[mid_idx], tail_pool[tail_idx]);
				mid_idx = mid_idx + 8'd1;
				if (mid_idx == 8'd0) begin
					fb = lead_pool[0] + ent;
					tail_pool[tail_idx] = scramble_tail(tail_pool[tail_idx], fb, tail_idx[2:0]);
					tail_idx = tail_idx + 8'd1;
				end
			end
			pending_bytes.push_back(drawn);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_bytes.size() == 0) begin
					fail_count++;
					$display("%0t: random_byte expected none, got %02h", $time, random_byte);
				end else begin
					want = pending_bytes.pop_front();
					if (random_byte !== want) begin
						fail_count++;
						$display("%0t: random_byte expected %02h, got %02h",
							$time, want, random_byte);
					end
				end
			end
			if (in_valid && in_ready)
				advance_pools(cpbp_pkg::req_t'(req_type), entropy);
		end
	end

	always @(posedge clk) begin
		if (hold_token !== hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input cpbp_pkg::req_t req, input logic [7:0] ent);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		entropy <= ent;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// Every pool entry is written once before any byte is drawn.
	task automatic test_seed_pools();
		int n;
		set_idling(0, 0);
		send_item(cpbp_pkg::REQ_SEED, 8'h00);
		send_item(cpbp_pkg::REQ_SEED, 8'hFF);
		send_item(cpbp_pkg::REQ_SEED, 8'h80);
		send_item(cpbp_pkg::REQ_SEED, 8'h01);
		for (n = 4; n < 3 * cpbp_pkg::POOL_DEPTH; n++)
			send_item(cpbp_pkg::REQ_SEED, 8'($urandom_range(255)));
		drain_results();
	endtask

	// Extreme entropy values, reseeding from the first entry after the pools
	// are full, and seed and generate items interleaved.
	task automatic test_directed();
		send_item(cpbp_pkg::REQ_GEN, 8'h00);
		send_item(cpbp_pkg::REQ_GEN, 8'hFF);
		send_item(cpbp_pkg::REQ_GEN, 8'h80);
		send_item(cpbp_pkg::REQ_GEN, 8'h01);
		send_item(cpbp_pkg::REQ_SEED, 8'h00);
		send_item(cpbp_pkg::REQ_SEED, 8'hFF);
		send_item(cpbp_pkg::REQ_SEED, 8'h5A);
		send_item(cpbp_pkg::REQ_GEN, 8'h55);
		send_item(cpbp_pkg::REQ_SEED, 8'hAA);
		send_item(cpbp_pkg::REQ_GEN, 8'hAA);
		send_item(cpbp_pkg::REQ_SEED, 8'h55);
		send_item(cpbp_pkg::REQ_GEN, 8'h7F);
		send_item(cpbp_pkg::REQ_SEED, 8'hFE);
		send_item(cpbp_pkg::REQ_SEED, 8'h01);
		send_item(cpbp_pkg::REQ_GEN, 8'hFF);
		send_item(cpbp_pkg::REQ_GEN, 8'h00);
		drain_results();
	endtask

	// Long generate run so that the first index wraps and the second pool is
	// remixed with the third.
	task automatic test_pool_cascade();
		int n;
		set_idling(0, 0);
		for (n = 0; n < CASCADE_GENS; n++)
			send_item(cpbp_pkg::REQ_GEN, 8'($urandom_range(255)));
		drain_results();
	endtask

	// The receiver holds off while generate items keep coming, so the block
	// fills up and stops accepting; the sender then waits for every byte.
	task automatic test_output_hold();
		int n;
		set_idling(0, 0);
		hold_token <= ~hold_token;
		for (n = 0; n < 40; n++)
			send_item(cpbp_pkg::REQ_GEN, 8'($urandom_range(255)));
		drain_results();
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(54, 0);
				2: set_idling(0, 54);
				default: set_idling(25, 25);
			endcase
			for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
				if ($urandom_range(99) < 75)
					send_item(cpbp_pkg::REQ_GEN, 8'($urandom_range(255)));
				else
					send_item(cpbp_pkg::REQ_SEED, 8'($urandom_range(255)));
			end
		end
		set_idling(0, 0);
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= cpbp_pkg::REQ_SEED;
		entropy <= 8'h00;
		hold_token <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_seed_pools();
		test_directed();
		test_pool_cascade();
		test_output_hold();
		test_random_traffic();
		if (fail_count == 0 && pending_bytes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
sv/cpbp_pkg.sv
sv/cpbp_front.sv
sv/cpbp_queue.sv
sv/cpbp_back.sv
sv/cascaded_pool_byte_prng.sv
tb/tb_top.sv
